@@ src/rational_arithmetic_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared same-cycle and next-cycle implication checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau: check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau: check failed");

`endif

@@ src/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operand width, fit limit and opcode codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;

  // reduced magnitudes must stay below this (numerator may equal it if negative)
  localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_NEG   = 4'd4;
  localparam logic [3:0] OP_RECIP = 4'd5;
  localparam logic [3:0] OP_ABS   = 4'd6;
  localparam logic [3:0] OP_FLOOR = 4'd7;
  localparam logic [3:0] OP_CEIL  = 4'd8;
  localparam logic [3:0] OP_TRUNC = 4'd9;
  localparam logic [3:0] OP_MOD   = 4'd10;
  localparam logic [3:0] OP_REM   = 4'd11;
  localparam logic [3:0] OP_CMP   = 4'd12;

endpackage

@@ src/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact rational add/sub/mul/div, unary ops, floor/ceil/trunc, mod/rem and
// compare, with every result reduced by its gcd.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while the unit is idle, and the
// result is held on the out_ channel until taken. The path depends on opcode:
// the binary operations go through one 33x33 multiplier (up to three
// products), neg/recip/abs skip it, and then a binary gcd runs one shift or
// subtract per cycle on 64-bit magnitudes, followed by two restoring divisions
// by the gcd. floor/ceil/trunc take one 64-step division, mod/rem add a
// 64-step division before the reduction, compare ends after the combine
// subtract, and an invalid request (bad opcode, NaN operand outside compare,
// zero mod/rem divisor) answers in NaN form on the next cycle. The combine
// subtract, gcd, divider and mod fix-up all share one 65-bit subtractor.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_a_num,
  input  logic [30:0]        in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic [30:0]        in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic signed [31:0] out_int_result,
  output logic signed [1:0]  out_cmp_sign,
  output logic               out_equal,
  output logic               out_is_nan,
  output logic               out_overflow
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MA   = 5'd1;
  localparam logic [4:0] S_MB   = 5'd2;
  localparam logic [4:0] S_MC   = 5'd3;
  localparam logic [4:0] S_SUBX = 5'd4;
  localparam logic [4:0] S_MAG  = 5'd5;
  localparam logic [4:0] S_CMPF = 5'd6;
  localparam logic [4:0] S_MODS = 5'd7;
  localparam logic [4:0] S_DIV  = 5'd8;
  localparam logic [4:0] S_MODF = 5'd9;
  localparam logic [4:0] S_FLR  = 5'd10;
  localparam logic [4:0] S_RED  = 5'd11;
  localparam logic [4:0] S_GCD  = 5'd12;
  localparam logic [4:0] S_GQ1  = 5'd13;
  localparam logic [4:0] S_GQ2  = 5'd14;
  localparam logic [4:0] S_FIT  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [31:0] an_r, an_nxt, bn_r, bn_nxt;
  logic [30:0] ad_r, ad_nxt, bd_r, bd_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, d_r, d_nxt;
  logic [63:0] un_r, un_nxt, ud_r, ud_nxt;
  logic        neg_r, neg_nxt, sy_r, sy_nxt;
  logic [63:0] u_r, u_nxt, v_r, v_nxt;
  logic [5:0]  k_r, k_nxt, cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt, dvs_r, dvs_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic        o_valid_r, o_valid_nxt;
  logic [31:0] o_num_r, o_num_nxt, o_int_r, o_int_nxt;
  logic [30:0] o_den_r, o_den_nxt;
  logic [1:0]  o_cmp_r, o_cmp_nxt;
  logic        o_eq_r, o_eq_nxt, o_nan_r, o_nan_nxt, o_ovf_r, o_ovf_nxt;

  // shared multiplier
  logic signed [32:0] m_a, m_b;
  logic signed [65:0] m_p;
  // shared subtractor
  logic [64:0] s_a, s_b;
  logic [65:0] s_full;
  logic        s_borrow;

  logic        u_ge;
  logic [64:0] rem_sh;
  logic [63:0] a_sext, a_mag;
  logic        in_anan, in_bnan, in_bad, need_b;
  logic        bump, too_big, is_int_op;
  logic [31:0] fit_num;

  assign m_p      = m_a * m_b;
  assign s_full   = {1'b0, s_a} - {1'b0, s_b};
  assign s_borrow = s_full[65];
  assign u_ge     = (u_r >= v_r);
  assign rem_sh   = {rem_r[63:0], dvd_r[63]};

  assign a_sext  = {{32{in_a_num[31]}}, in_a_num};
  assign a_mag   = in_a_num[31] ? (64'd0 - a_sext) : a_sext;
  assign in_anan = (in_a_den == 31'd0);
  assign in_bnan = (in_b_den == 31'd0);
  assign need_b  = (in_opcode == rau_pkg::OP_ADD) || (in_opcode == rau_pkg::OP_SUB) ||
                   (in_opcode == rau_pkg::OP_MUL) || (in_opcode == rau_pkg::OP_DIV) ||
                   (in_opcode == rau_pkg::OP_MOD) || (in_opcode == rau_pkg::OP_REM);
  assign in_bad  = (in_opcode > rau_pkg::OP_CMP) ||
                   ((in_opcode != rau_pkg::OP_CMP) && in_anan) ||
                   (need_b && in_bnan) ||
                   (((in_opcode == rau_pkg::OP_MOD) || (in_opcode == rau_pkg::OP_REM)) &&
                    (in_b_num == 32'sd0));

  assign is_int_op = (op_r == rau_pkg::OP_FLOOR) || (op_r == rau_pkg::OP_CEIL) ||
                     (op_r == rau_pkg::OP_TRUNC);
  assign bump      = (rem_r[63:0] != 64'd0) &&
                     (((op_r == rau_pkg::OP_FLOOR) && neg_r) ||
                      ((op_r == rau_pkg::OP_CEIL) && !neg_r));
  assign too_big   = (neg_r ? (un_r > rau_pkg::LIM) : (un_r >= rau_pkg::LIM)) ||
                     (ud_r >= rau_pkg::LIM);
  assign fit_num   = neg_r ? (32'd0 - un_r[31:0]) : un_r[31:0];

  // multiplier operands
  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state_r)
      S_MA: begin
        m_a = {an_r[31], an_r};
        m_b = (op_r == rau_pkg::OP_MUL) ? {bn_r[31], bn_r} : {2'b00, bd_r};
      end
      S_MB: begin
        // add folds the sign into y so the combine step is always x - y
        m_a = (op_r == rau_pkg::OP_ADD) ? (33'sd0 - {bn_r[31], bn_r}) : {bn_r[31], bn_r};
        m_b = {2'b00, ad_r};
      end
      S_MC: begin
        m_a = {2'b00, ad_r};
        m_b = (op_r == rau_pkg::OP_DIV) ? {bn_r[31], bn_r} : {2'b00, bd_r};
      end
      default: begin
      end
    endcase
  end

  // subtractor operands
  always_comb begin
    s_a = '0;
    s_b = '0;
    unique case (state_r)
      S_SUBX: begin
        s_a = {x_r[63], x_r};
        s_b = {y_r[63], y_r};
      end
      S_GCD: begin
        s_a = u_ge ? {1'b0, u_r} : {1'b0, v_r};
        s_b = u_ge ? {1'b0, v_r} : {1'b0, u_r};
      end
      S_DIV: begin
        s_a = rem_sh;
        s_b = {1'b0, dvs_r};
      end
      S_MODF: begin
        s_a = {1'b0, dvs_r};
        s_b = {1'b0, rem_r[63:0]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    op_nxt      = op_r;
    an_nxt      = an_r;
    ad_nxt      = ad_r;
    bn_nxt      = bn_r;
    bd_nxt      = bd_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    d_nxt       = d_r;
    un_nxt      = un_r;
    ud_nxt      = ud_r;
    neg_nxt     = neg_r;
    sy_nxt      = sy_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    dvd_nxt     = dvd_r;
    dvs_nxt     = dvs_r;
    rem_nxt     = rem_r;
    o_valid_nxt = o_valid_r;
    o_num_nxt   = o_num_r;
    o_den_nxt   = o_den_r;
    o_int_nxt   = o_int_r;
    o_cmp_nxt   = o_cmp_r;
    o_eq_nxt    = o_eq_r;
    o_nan_nxt   = o_nan_r;
    o_ovf_nxt   = o_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          an_nxt    = in_a_num;
          ad_nxt    = in_a_den;
          bn_nxt    = in_b_num;
          bd_nxt    = in_b_den;
          o_int_nxt = '0;
          o_cmp_nxt = '0;
          o_eq_nxt  = 1'b0;
          o_ovf_nxt = 1'b0;
          if (in_bad) begin
            o_num_nxt   = 32'd1;
            o_den_nxt   = '0;
            o_nan_nxt   = 1'b1;
            o_valid_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            unique case (in_opcode)
              rau_pkg::OP_NEG: begin
                x_nxt     = 64'd0 - a_sext;
                d_nxt     = {33'd0, in_a_den};
                state_nxt = S_MAG;
              end
              rau_pkg::OP_RECIP: begin
                x_nxt     = {33'd0, in_a_den};
                d_nxt     = a_sext;
                state_nxt = S_MAG;
              end
              rau_pkg::OP_ABS: begin
                x_nxt     = a_mag;
                d_nxt     = {33'd0, in_a_den};
                state_nxt = S_MAG;
              end
              rau_pkg::OP_FLOOR, rau_pkg::OP_CEIL, rau_pkg::OP_TRUNC: begin
                dvd_nxt   = a_mag;
                dvs_nxt   = {33'd0, in_a_den};
                rem_nxt   = '0;
                cnt_nxt   = '0;
                neg_nxt   = in_a_num[31];
                ret_nxt   = S_FLR;
                state_nxt = S_DIV;
              end
              default: state_nxt = S_MA;
            endcase
          end
        end
      end
      S_MA: begin
        x_nxt     = m_p[63:0];
        state_nxt = ((op_r == rau_pkg::OP_MUL) || (op_r == rau_pkg::OP_DIV)) ? S_MC : S_MB;
      end
      S_MB: begin
        y_nxt     = m_p[63:0];
        state_nxt = (op_r == rau_pkg::OP_CMP) ? S_SUBX : S_MC;
      end
      S_MC: begin
        d_nxt = m_p[63:0];
        if ((op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB)) begin
          state_nxt = S_SUBX;
        end else if ((op_r == rau_pkg::OP_MUL) || (op_r == rau_pkg::OP_DIV)) begin
          state_nxt = S_MAG;
        end else begin
          state_nxt = S_MODS;
        end
      end
      S_SUBX: begin
        x_nxt     = s_full[63:0];
        state_nxt = (op_r == rau_pkg::OP_CMP) ? S_CMPF : S_MAG;
      end
      S_MAG: begin
        un_nxt    = x_r[63] ? (64'd0 - x_r) : x_r;
        ud_nxt    = d_r[63] ? (64'd0 - d_r) : d_r;
        neg_nxt   = x_r[63] ^ d_r[63];
        state_nxt = S_RED;
      end
      S_CMPF: begin
        if ((ad_r == 31'd0) || (bd_r == 31'd0)) begin
          o_cmp_nxt = 2'b00;
        end else if (x_r[63]) begin
          o_cmp_nxt = 2'b11;
        end else begin
          o_cmp_nxt = (x_r != 64'd0) ? 2'b01 : 2'b00;
        end
        // reduced forms match iff both NaN or equal values
        o_eq_nxt    = ((ad_r == 31'd0) && (bd_r == 31'd0)) ||
                      ((ad_r != 31'd0) && (bd_r != 31'd0) && (x_r == 64'd0));
        o_num_nxt   = 32'd0;
        o_den_nxt   = 31'd1;
        o_nan_nxt   = 1'b0;
        o_valid_nxt = 1'b1;
        state_nxt   = S_OUT;
      end
      S_MODS: begin
        dvd_nxt   = x_r[63] ? (64'd0 - x_r) : x_r;
        dvs_nxt   = y_r[63] ? (64'd0 - y_r) : y_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        neg_nxt   = x_r[63];
        sy_nxt    = y_r[63];
        ret_nxt   = S_MODF;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring step: quotient bits shift into dvd from the bottom
        rem_nxt = s_borrow ? rem_sh : s_full[64:0];
        dvd_nxt = {dvd_r[62:0], !s_borrow};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ret_r;
        end
      end
      S_MODF: begin
        // floored mod: remainder takes the divisor's sign
        if ((op_r == rau_pkg::OP_MOD) && (rem_r[63:0] != 64'd0) && (neg_r != sy_r)) begin
          un_nxt  = s_full[63:0];
          neg_nxt = sy_r;
        end else begin
          un_nxt = rem_r[63:0];
        end
        ud_nxt    = d_r;
        state_nxt = S_RED;
      end
      S_FLR: begin
        un_nxt    = dvd_r + {63'd0, bump};
        ud_nxt    = 64'd1;
        state_nxt = S_FIT;
      end
      S_RED: begin
        if (ud_r == 64'd0) begin
          o_num_nxt   = 32'd1;
          o_den_nxt   = '0;
          o_nan_nxt   = 1'b1;
          o_valid_nxt = 1'b1;
          state_nxt   = S_OUT;
        end else if (un_r == 64'd0) begin
          o_num_nxt   = 32'd0;
          o_den_nxt   = 31'd1;
          o_nan_nxt   = 1'b0;
          o_valid_nxt = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          u_nxt     = un_r;
          v_nxt     = ud_r;
          k_nxt     = '0;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        priority if ((u_r == 64'd0) || (v_r == 64'd0)) begin
          dvs_nxt   = (u_r | v_r) << k_r;
          dvd_nxt   = un_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          ret_nxt   = S_GQ1;
          state_nxt = S_DIV;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 6'd1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_ge) begin
          u_nxt = s_full[64:1];
        end else begin
          v_nxt = s_full[64:1];
        end
      end
      S_GQ1: begin
        un_nxt    = dvd_r;
        dvd_nxt   = ud_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        ret_nxt   = S_GQ2;
        state_nxt = S_DIV;
      end
      S_GQ2: begin
        ud_nxt    = dvd_r;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        if (too_big) begin
          o_num_nxt = 32'd1;
          o_den_nxt = '0;
          o_nan_nxt = 1'b1;
          o_ovf_nxt = 1'b1;
          o_int_nxt = '0;
        end else begin
          o_num_nxt = fit_num;
          o_den_nxt = ud_r[30:0];
          o_nan_nxt = (ud_r[30:0] == 31'd0);
          o_int_nxt = is_int_op ? fit_num : 32'd0;
        end
        o_valid_nxt = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          o_valid_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    op_r    <= op_nxt;
    an_r    <= an_nxt;
    ad_r    <= ad_nxt;
    bn_r    <= bn_nxt;
    bd_r    <= bd_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    d_r     <= d_nxt;
    un_r    <= un_nxt;
    ud_r    <= ud_nxt;
    neg_r   <= neg_nxt;
    sy_r    <= sy_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    o_num_r <= o_num_nxt;
    o_den_r <= o_den_nxt;
    o_int_r <= o_int_nxt;
    o_cmp_r <= o_cmp_nxt;
    o_eq_r  <= o_eq_nxt;
    o_nan_r <= o_nan_nxt;
    o_ovf_r <= o_ovf_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = o_valid_r;
  assign out_res_num    = o_num_r;
  assign out_res_den    = o_den_r;
  assign out_int_result = o_int_r;
  assign out_cmp_sign   = o_cmp_r;
  assign out_equal      = o_eq_r;
  assign out_is_nan     = o_nan_r;
  assign out_overflow   = o_ovf_r;

endmodule

@@ src/rau_checker.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit port checker
// Watches the top level's ports and flags result and sequencing slips.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_res_num,
  input logic [30:0]        out_res_den,
  input logic               out_is_nan,
  input logic               out_overflow
);

  // NaN flag tracks the denominator
  `RAU_ASSERT_IMP(a_nan_den, out_valid, out_is_nan == (out_res_den == 31'd0))
  // overflow always comes back in NaN form
  `RAU_ASSERT_IMP(a_ovf_nan, out_valid && out_overflow, out_is_nan && (out_res_num == 32'sd1))
  // one request in flight: busy right after taking one
  `RAU_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready)
  `RAU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_res_num))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
